// File: rtl/core/sptq_pkg.sv
// Shared types and codes for the sorted priority task queue.
// No dependencies; imported by the cell and the top level.
`default_nettype none

package sptq_pkg;

  localparam int TASK_W = 8;
  localparam int PRIO_W = 8;
  localparam int OCC_W  = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // Input transaction payload.
  typedef struct packed {
    logic              op;
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] priority_req;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [1:0]        status;
    logic              task_valid;
    logic [TASK_W-1:0] task_out;
    logic [OCC_W-1:0]  occupancy;
  } out_item_t;

  // One queue slot.
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TASK_W-1:0] task_id;
  } entry_t;

  // Command broadcast to every cell in the chain.
  typedef struct packed {
    logic              ins;
    logic              pop;
    logic [PRIO_W-1:0] prio;
    logic [TASK_W-1:0] task_id;
  } cell_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/sptq_cell.sv
// One slot of the sorted queue chain: holds an entry, compares on insert,
// shifts toward the tail on insert and toward the head on pop. Uses sptq_pkg.
`default_nettype none

module sptq_cell (
  input  wire                 clk,
  input  wire                 occupied,
  input  sptq_pkg::cell_cmd_t cmd,
  input  wire                 below_left,
  input  sptq_pkg::entry_t    ent_left,
  input  sptq_pkg::entry_t    ent_right,
  output logic                below,
  output sptq_pkg::entry_t    ent
);
  import sptq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // New task lands at or before this slot: slot free or strictly lower prio.
  assign below = !occupied || (cmd.prio > ent_r.prio);
  assign ent   = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.ins && below) begin
      if (below_left) begin
        ent_nxt = ent_left;
      end else begin
        ent_nxt.prio    = cmd.prio;
        ent_nxt.task_id = cmd.task_id;
      end
    end else if (cmd.pop) begin
      ent_nxt = ent_right;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/core/sorted_priority_task_queue.sv
// Top level of the sorted priority task queue: a chain of sptq_cell slots,
// the entry count and the result register. Uses sptq_pkg and sptq_cell.
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+-----------------------------
//  in      | input     | in_valid / in_stall | in_data  (op, task_id, prio)
//  out     | output    | out_valid/out_stall | out_data (status, task, occ)
//
// One transaction per cycle while in_stall is low: every cell compares the
// incoming priority in parallel and the whole chain shifts by one slot in the
// same edge; out_valid rises in the cycle after acceptance.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; slot contents are not cleared, the count marks which are live.
// in_stall rises only while a result is held and out_stall is high.
`default_nettype none

module sorted_priority_task_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  sptq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output sptq_pkg::out_item_t out_data
);
  import sptq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  out_item_t        out_data_r;
  out_item_t        out_data_nxt;

  logic             in_acc;
  logic             is_full;
  logic             is_empty;
  cell_cmd_t        cmd;

  entry_t           ent   [QUEUE_DEPTH];
  logic             below [QUEUE_DEPTH];

  // Result register; holds while out_stall is high, else drains or refills.
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  assign is_full  = (count_r >= CNT_W'(QUEUE_DEPTH));
  assign is_empty = (count_r == '0);

  always_comb begin
    cmd.ins     = in_acc && (in_data.op == OP_INSERT) && !is_full;
    cmd.pop     = in_acc && (in_data.op == OP_POP) && !is_empty;
    cmd.prio    = in_data.priority_req;
    cmd.task_id = in_data.task_id;
  end

  // Slot chain, head at index 0.
  for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
    logic   occ;
    logic   bl;
    entry_t el;
    entry_t er;

    assign occ = (count_r > CNT_W'(gi));

    if (gi == 0) begin : g_head
      assign bl = 1'b0;
      assign el = ent[gi];
    end else begin : g_mid
      assign bl = below[gi-1];
      assign el = ent[gi-1];
    end

    if (gi == QUEUE_DEPTH - 1) begin : g_tail
      assign er = ent[gi];
    end else begin : g_inner
      assign er = ent[gi+1];
    end

    sptq_cell u_cell (
      .clk        (clk),
      .occupied   (occ),
      .cmd        (cmd),
      .below_left (bl),
      .ent_left   (el),
      .ent_right  (er),
      .below      (below[gi]),
      .ent        (ent[gi])
    );
  end

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (in_acc) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.status     = STATUS_OK;
      out_data_nxt.task_valid = 1'b0;
      out_data_nxt.task_out   = '0;
      if (in_data.op == OP_INSERT) begin
        if (is_full) begin
          out_data_nxt.status = STATUS_FULL;
        end
      end else if (is_empty) begin
        out_data_nxt.status = STATUS_EMPTY;
      end else begin
        out_data_nxt.task_valid = 1'b1;
        out_data_nxt.task_out   = ent[0].task_id;
      end
      out_data_nxt.occupancy = OCC_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Count never runs past the chain length.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  // A pop of an empty queue reports empty and leaves the count at zero.
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.op == OP_POP && is_empty) |=>
      (out_valid && out_data.status == STATUS_EMPTY && count_r == '0))
    else $error("pop on empty queue mishandled");

  // An accepted insert into a non-full queue grows it by exactly one.
  a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.op == OP_INSERT && !is_full) |=>
      (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow queue");

  // A returned task always comes with an ok status.
  a_task_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.task_valid) |-> (out_data.status == STATUS_OK))
    else $error("task returned with error status");

endmodule

`default_nettype wire
